// File: sv/lo_pkg.sv
// shared types and constants for the lights out gf(2) solver
package lo_pkg;

   localparam int MAX_ROWS  = 8;
   localparam int MAX_COLS  = 8;
   localparam int CELLS     = MAX_ROWS * MAX_COLS;
   localparam int IDX_W     = $clog2(CELLS);
   localparam int CNT_W     = IDX_W + 2;
   localparam int DIM_W     = 4;

   localparam logic [DIM_W-1:0] CSR_GRID_ROWS = 4'd0;
   localparam logic [DIM_W-1:0] CSR_GRID_COLS = 4'd1;

   // one equation: coefficient bits, right-hand side and a valid flag
   typedef struct packed {
      logic             vld;
      logic             rhs;
      logic [CELLS-1:0] coef;
   } lo_row_type;

   // controls broadcast to every cell
   typedef struct packed {
      logic clr;
      logic elim;
      logic shift;
   } lo_ctl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ELIM,
      ST_BACK,
      ST_DONE
   } lo_state_type;

endpackage

// File: sv/lo_cell.sv
// one elimination cell: keeps the row whose leading column is its own index
module lo_cell (
   input  logic                       clock,
   input  logic                       reset,
   input  lo_pkg::lo_ctl_type         ctl,
   input  logic [lo_pkg::IDX_W-1:0]   col_idx,
   input  lo_pkg::lo_row_type         eq_in,
   output lo_pkg::lo_row_type         eq_out,
   input  lo_pkg::lo_row_type         row_in,
   output lo_pkg::lo_row_type         row_out
);
   import lo_pkg::*;

   lo_row_type row_ff, row_next_in;
   lo_row_type eq_ff, eq_next_in;

   // reduce the passing equation or capture it as this column's pivot
   always_comb begin
      row_next_in = row_ff;
      eq_next_in  = eq_in;
      if (ctl.shift) begin
         row_next_in = row_in;
         eq_next_in  = '0;
      end else if (ctl.elim) begin
         if (eq_in.vld && eq_in.coef[col_idx]) begin
            if (row_ff.vld) begin
               eq_next_in.coef = eq_in.coef ^ row_ff.coef;
               eq_next_in.rhs  = eq_in.rhs ^ row_ff.rhs;
            end else begin
               row_next_in    = eq_in;
               eq_next_in.vld = 1'b0;
            end
         end
      end else begin
         eq_next_in.vld = 1'b0;
      end
      // a new beat empties the cell
      if (ctl.clr) begin
         row_next_in.vld = 1'b0;
         eq_next_in.vld  = 1'b0;
      end
   end

   // row and pass-on registers; valid flags cleared by reset
   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff.vld <= 1'b0;
         eq_ff.vld  <= 1'b0;
      end else begin
         row_ff <= row_next_in;
         eq_ff  <= eq_next_in;
      end
   end

   assign eq_out  = eq_ff;
   assign row_out = row_ff;

endmodule

// File: sv/lights_out_gf2_solver.sv
// top level: equation feeder, chain of elimination cells and back-substitution
//
//  channel | ports                          | direction
//  req     | req_valid req_stall req_board_lights | in
//  rsp     | rsp_valid rsp_stall rsp_press_mask rsp_solvable | out
//  csr     | csr_valid csr_ready csr_index csr_wdata | in
//
// an item is eliminated through the 64-cell chain, then back-substituted as
// rows shift out of the chain, followed by a handover (result load and
// return to idle); no new beat is taken until the block is idle again.
// reset is synchronous and clears control state; registers go to 5 x 5.
// a finished result waits in the output register while the next beat is
// taken; the last step holds only while that register is full and stalled.
module lights_out_gf2_solver (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [63:0]                 req_board_lights,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [63:0]                 rsp_press_mask,
   output logic                        rsp_solvable,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [lo_pkg::DIM_W-1:0]    csr_index,
   input  logic [lo_pkg::DIM_W-1:0]    csr_wdata
);
   import lo_pkg::*;

   lo_state_type state_ff, state_in;
   logic [DIM_W-1:0] rows_cfg_ff, cols_cfg_ff;
   logic [DIM_W-1:0] rows_eff, cols_eff;
   logic [CNT_W-1:0] cnt_ff, cnt_in, n_cells;
   logic [DIM_W-1:0] r_ff, r_in, c_ff, c_in;
   logic [CELLS-1:0] board_ff, board_in;
   logic [CELLS-1:0] x_ff, x_in;
   logic             bad_ff, bad_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [CELLS-1:0] press_ff, press_in;
   logic             solv_ff, solv_in;
   logic             req_acc, rsp_load, feed_on;
   logic [IDX_W-1:0] id, kk;
   lo_ctl_type       ctl;
   lo_row_type       feed_eq;
   lo_row_type       eq_chain  [CELLS+1];
   lo_row_type       row_chain [CELLS+1];

   assign csr_ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rows_cfg_ff <= 4'd5;
         cols_cfg_ff <= 4'd5;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_GRID_ROWS: rows_cfg_ff <= csr_wdata;
            CSR_GRID_COLS: cols_cfg_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // clamp grid size to 1..max
   always_comb begin
      rows_eff = rows_cfg_ff;
      cols_eff = cols_cfg_ff;
      if (rows_cfg_ff == '0) rows_eff = 4'd1;
      else if (rows_cfg_ff > DIM_W'(MAX_ROWS)) rows_eff = DIM_W'(MAX_ROWS);
      if (cols_cfg_ff == '0) cols_eff = 4'd1;
      else if (cols_cfg_ff > DIM_W'(MAX_COLS)) cols_eff = DIM_W'(MAX_COLS);
   end
   assign n_cells = CNT_W'(rows_eff) * CNT_W'(cols_eff);

   assign req_stall = (state_ff != ST_IDLE);
   assign req_acc   = req_valid && !req_stall;
   assign rsp_load  = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);
   assign feed_on   = (state_ff == ST_ELIM) && (cnt_ff < n_cells);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_acc) state_in = ST_ELIM;
         ST_ELIM: if (cnt_ff == n_cells + CNT_W'(CELLS - 1)) state_in = ST_BACK;
         ST_BACK: if (cnt_ff == CNT_W'(CELLS - 1)) state_in = ST_DONE;
         ST_DONE: if (rsp_load) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // cell controls
   always_comb begin
      ctl       = '0;
      ctl.clr   = req_acc;
      ctl.elim  = (state_ff == ST_ELIM);
      ctl.shift = (state_ff == ST_BACK);
   end

   // equation feeder: one cell equation a cycle in row-major order
   assign id = cnt_ff[IDX_W-1:0];
   always_comb begin
      feed_eq      = '0;
      feed_eq.vld  = feed_on;
      feed_eq.rhs  = board_ff[id];
      feed_eq.coef = CELLS'(1) << id;
      if (r_ff != '0)
         feed_eq.coef[id - IDX_W'(cols_eff)] = 1'b1;
      if (r_ff + 4'd1 < rows_eff)
         feed_eq.coef[id + IDX_W'(cols_eff)] = 1'b1;
      if (c_ff != '0)
         feed_eq.coef[id - IDX_W'(1)] = 1'b1;
      if (c_ff + 4'd1 < cols_eff)
         feed_eq.coef[id + IDX_W'(1)] = 1'b1;
   end

   // counters, board, solution and inconsistency flag
   assign kk = IDX_W'(CELLS - 1) - cnt_ff[IDX_W-1:0];
   always_comb begin
      cnt_in   = cnt_ff + CNT_W'(1);
      r_in     = r_ff;
      c_in     = c_ff;
      board_in = board_ff;
      x_in     = x_ff;
      bad_in   = bad_ff;
      if (req_acc) begin
         cnt_in   = '0;
         r_in     = '0;
         c_in     = '0;
         board_in = req_board_lights;
         x_in     = '0;
         bad_in   = 1'b0;
      end else begin
         if (feed_on) begin
            if (c_ff + 4'd1 == cols_eff) begin
               c_in = '0;
               r_in = r_ff + 4'd1;
            end else begin
               c_in = c_ff + 4'd1;
            end
         end
         if (state_ff == ST_ELIM) begin
            if (eq_chain[CELLS].vld && eq_chain[CELLS].rhs) bad_in = 1'b1;
            if (state_in == ST_BACK) cnt_in = '0;
         end
         if (state_ff == ST_BACK)
            x_in[kk] = row_chain[CELLS].vld &
                       (row_chain[CELLS].rhs ^ (^(row_chain[CELLS].coef & x_ff)));
         if (state_ff == ST_DONE || state_ff == ST_IDLE) cnt_in = cnt_ff;
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      press_in     = press_ff;
      solv_in      = solv_ff;
      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         press_in     = bad_ff ? '0 : x_ff;
         solv_in      = !bad_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
      end
      r_ff     <= r_in;
      c_ff     <= c_in;
      board_ff <= board_in;
      x_ff     <= x_in;
      bad_ff   <= bad_in;
      press_ff <= press_in;
      solv_ff  <= solv_in;
   end

   // chain of cells
   assign eq_chain[0]  = feed_eq;
   assign row_chain[0] = '0;
   for (genvar i = 0; i < CELLS; i++) begin : g_cell
      lo_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .ctl     (ctl),
         .col_idx (IDX_W'(i)),
         .eq_in   (eq_chain[i]),
         .eq_out  (eq_chain[i+1]),
         .row_in  (row_chain[i]),
         .row_out (row_chain[i+1])
      );
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_press_mask = press_ff;
   assign rsp_solvable   = solv_ff;

`ifndef SYNTH
   a_unsolv_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !solv_ff |-> press_ff == '0)
      else $error("unsolvable result carries presses");
   a_accept_elim: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> state_ff == ST_ELIM && cnt_ff == '0)
      else $error("accepted beat did not start elimination");
   a_load_full: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> rsp_valid_ff && state_ff == ST_IDLE)
      else $error("result load lost");
`endif

endmodule
